### design/linear_gain_fade_ramp_defines.svh
// ----------------------------------------------------------------------------
// Linear gain fade ramp assertion macros
// Shared concurrent assertion forms for the fade ramp design.
// ----------------------------------------------------------------------------
`ifndef LINEAR_GAIN_FADE_RAMP_DEFINES_SVH
`define LINEAR_GAIN_FADE_RAMP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LGFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgfr: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LGFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgfr: next-cycle check failed");

`endif

### design/lgfr_pkg.sv
// ----------------------------------------------------------------------------
// Linear gain fade ramp package
// Mode codes, reset values and parameter defaults shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgfr_pkg;

  // Default widths.
  localparam int LENGTH_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 15;

  // Fixed port widths.
  localparam int FADE_LEN_W = 16;
  localparam int GAIN_OUT_W = 16;

  // Fade length after reset.
  localparam logic [FADE_LEN_W-1:0] FADE_LENGTH_RESET = 16'd256;

  // Fade modes.
  typedef enum logic [1:0] {
    MODE_MUTED    = 2'd0,
    MODE_FADE_IN  = 2'd1,
    MODE_FADE_OUT = 2'd2
  } mode_t;

endpackage

### design/lgfr_div.sv
// ----------------------------------------------------------------------------
// Fade ramp serial divider
// Restoring divider, one quotient bit per cycle, for a quotient known to
// fit in QUOT_W bits (dividend below divisor times 2^QUOT_W).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgfr_div #(
  parameter int QUOT_W = lgfr_pkg::GAIN_FRAC_BITS_DEF + 1,
  parameter int DEN_W  = lgfr_pkg::LENGTH_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [QUOT_W+DEN_W-1:0] dividend,
  input  logic [DEN_W-1:0]        divisor,
  output logic                    done,
  output logic [QUOT_W-1:0]       quotient
);

  import lgfr_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [QUOT_W-1:0] qsh;
  logic [CNT_W-1:0]  cnt;
  logic [DEN_W:0]    cat;
  logic [DEN_W:0]    trial;

  // One trial subtraction of the divisor from the shifted remainder.
  assign cat   = {rem, qsh[QUOT_W-1]};
  assign trial = cat - {1'b0, den};

  // Step sequencing: the counter holds the quotient bits still to produce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(QUOT_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: the upper dividend bits seed the remainder, the lower bits
  // shift out as the quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[QUOT_W+DEN_W-1:QUOT_W];
      qsh <= dividend[QUOT_W-1:0];
      den <= divisor;
    end else if (cnt != '0) begin
      if (!trial[DEN_W]) begin
        rem <= trial[DEN_W-1:0];
        qsh <= {qsh[QUOT_W-2:0], 1'b1};
      end else begin
        rem <= cat[DEN_W-1:0];
        qsh <= {qsh[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = qsh;

endmodule

### design/linear_gain_fade_ramp.sv
// Sequence: a ramping tick passes the EVAL, LOAD, DIV and OUT states, waiting in DIV on
// the bit-serial divider; a settled or zero-length tick passes the EVAL and OUT states only.
// Throughput: one tick at a time; the next tick is taken only once the word of the last one
// is loaded into the output register, and OUT waits while the output is stalled.
// Reset: rst is synchronous, active high; fade length returns to 256 and the ramp is
// muted at zero gain. A fade length write also clears the ramp state.
// ----------------------------------------------------------------------------
// Linear gain fade ramp
// Per-tick gain ramp between zero and unity with a shared serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_gain_fade_ramp_defines.svh"

module linear_gain_fade_ramp #(
  parameter int LENGTH_BITS    = lgfr_pkg::LENGTH_BITS_DEF,
  parameter int GAIN_FRAC_BITS = lgfr_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Fade length register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Tick in; tdata [1:0] requested_mode, [7:2] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Gain out; tdata [15:0] gain, [16] is_muted, [17] is_full, [23:18] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  import lgfr_pkg::*;

  localparam int LW = LENGTH_BITS;
  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int PW = GW + LW;
  localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                state;
  logic [FADE_LEN_W-1:0] fade_length;
  mode_t                 cur_mode;
  mode_t                 req_mode;
  logic [LW-1:0]         pos;
  logic [LW-1:0]         len_eff;
  logic [GW-1:0]         start_gain;
  logic [GW-1:0]         target_gain;
  logic [GW-1:0]         present_gain;
  logic [GW-1:0]         diff;
  logic                  ramp_up;
  logic                  muted_flag;
  logic                  full_flag;
  logic [PW-1:0]         dividend;
  logic                  div_start;
  logic                  div_done;
  logic [GW-1:0]         quotient;
  logic                  in_fire;
  logic                  cfg_fire;

  // Effective length saturates at the position counter range.
  if (LENGTH_BITS >= FADE_LEN_W) begin : g_len_wide
    assign len_eff = LW'(fade_length);
  end else begin : g_len_cap
    assign len_eff = (fade_length > FADE_LEN_W'((1 << LENGTH_BITS) - 1)) ? '1
                                                               : fade_length[LW-1:0];
  end

  // Requested mode decode; the unused code means muted.
  always_comb begin
    unique case (s_axis_tdata[1:0])
      2'd1:    req_mode = MODE_FADE_IN;
      2'd2:    req_mode = MODE_FADE_OUT;
      default: req_mode = MODE_MUTED;
    endcase
  end

  // Handshakes.
  assign cfg_ready     = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Ramp product feeds the divider straight from the registered operands.
  assign div_start = (state == ST_LOAD);
  assign dividend  = {LW'(0), diff} * {GW'(0), pos};

  lgfr_div #(
    .QUOT_W (GW),
    .DEN_W  (LW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (len_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer with ramp state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fade_length   <= FADE_LENGTH_RESET;
      cur_mode      <= MODE_MUTED;
      pos           <= '0;
      start_gain    <= '0;
      target_gain   <= '0;
      present_gain  <= '0;
      muted_flag    <= 1'b1;
      full_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A taken word clears valid unless a new word is loaded in its place.
      if (m_axis_tvalid && m_axis_tready && state != ST_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_fire) begin
            fade_length  <= cfg_data;
            cur_mode     <= MODE_MUTED;
            pos          <= '0;
            start_gain   <= '0;
            target_gain  <= '0;
            present_gain <= '0;
            muted_flag   <= 1'b1;
            full_flag    <= 1'b0;
          end else if (in_fire) begin
            // A changed request re-arms the ramp from the present gain.
            if (req_mode != cur_mode) begin
              cur_mode    <= req_mode;
              pos         <= '0;
              start_gain  <= present_gain;
              target_gain <= (req_mode == MODE_FADE_IN) ? UNITY : '0;
            end
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          priority if (len_eff == '0) begin
            present_gain <= '0;
            muted_flag   <= 1'b1;
            full_flag    <= 1'b0;
            cur_mode     <= MODE_MUTED;
            state        <= ST_OUT;
          end else if (pos >= len_eff) begin
            // Ramp finished: settle on the target.
            present_gain <= target_gain;
            muted_flag   <= (target_gain == '0);
            full_flag    <= (target_gain != '0);
            cur_mode     <= (target_gain == '0) ? MODE_MUTED : MODE_FADE_IN;
            state        <= ST_OUT;
          end else begin
            ramp_up <= (target_gain >= start_gain);
            diff    <= (target_gain >= start_gain) ? (target_gain - start_gain)
                                                   : (start_gain - target_gain);
            state   <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            present_gain <= ramp_up ? (start_gain + quotient) : (start_gain - quotient);
            pos          <= pos + 1'b1;
            state        <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'b0, full_flag, muted_flag, GAIN_OUT_W'(present_gain)};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the ramp state and the output handshake.
  `LGFR_ASSERT_IMPL(a_flags_excl, clk, rst, full_flag, !muted_flag)
  `LGFR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `LGFR_ASSERT_IMPL(a_pos_range, clk, rst, state == ST_LOAD || state == ST_DIV, pos < len_eff)
  `LGFR_ASSERT_NEXT(a_div_to_out, clk, rst, state == ST_DIV && div_done, state == ST_OUT)

endmodule
